/* rtl/ruqs_pkg.sv */
// ----------------------------------------------------------------------------
// ruqs_pkg
// Shared types and constants for the uniform mod-q rejection sampler.
// ----------------------------------------------------------------------------
package ruqs_pkg;

    localparam int WORD_W   = 64;
    localparam int HELD_W   = 7;
    localparam int IDX_W    = 12;
    localparam int OUT_TD_W = 80;

    localparam logic [WORD_W-1:0] MODULUS_RST = 64'd2;
    localparam logic [HELD_W-1:0] WIDTH_RST   = 7'd2;
    localparam logic [HELD_W-1:0] WIDTH_FULL  = 7'd64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WIDTH,
        S_MERGE,
        S_DRAIN,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic              merge;
        logic [WORD_W-1:0] store;
        logic [HELD_W-1:0] held;
        logic [WORD_W-1:0] word;
        logic [HELD_W-1:0] width;
        logic [WORD_W-1:0] modulus;
    } t_draw_req;

    typedef struct packed {
        logic [WORD_W-1:0] draw;
        logic              accept;
        logic [WORD_W-1:0] store;
        logic [HELD_W-1:0] held;
    } t_draw_res;

endpackage

/* rtl/ruqs_width_scan.sv */
// ----------------------------------------------------------------------------
// ruqs_width_scan
// Iterative bit-width finder: shifts the modulus right one bit per cycle.
// ----------------------------------------------------------------------------
module ruqs_width_scan
    import ruqs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_value,
    output logic              o_busy,
    output logic [HELD_W-1:0] o_width
);

    logic              r_busy, n_busy;
    logic [WORD_W-1:0] r_scan, n_scan;
    logic [HELD_W-1:0] r_w, n_w;

    always_comb begin
        n_busy = r_busy;
        n_scan = r_scan;
        n_w    = r_w;
        if (i_start) begin
            n_busy = 1'b1;
            n_scan = i_value;
            n_w    = '0;
        end else if (r_busy) begin
            if (r_scan == '0) begin
                n_busy = 1'b0;
            end else begin
                n_scan = r_scan >> 1;
                n_w    = r_w + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_w    <= WIDTH_RST;
        end else begin
            r_busy <= n_busy;
            r_w    <= n_w;
        end
        r_scan <= n_scan;
    end

    assign o_busy  = r_busy;
    assign o_width = r_w;

endmodule

/* rtl/ruqs_draw_unit.sv */
// ----------------------------------------------------------------------------
// ruqs_draw_unit
// Shared draw unit: extracts one draw from the bit buffer (or merges it with
// a new word), updates the buffer, and compares the draw to the modulus.
// ----------------------------------------------------------------------------
module ruqs_draw_unit
    import ruqs_pkg::*;
(
    input  t_draw_req i_req,
    output t_draw_res o_res
);

    logic [WORD_W-1:0] w_ones;
    logic [WORD_W-1:0] w_mask_w;
    logic [WORD_W-1:0] w_mask_r;
    logic [HELD_W-1:0] w_r;
    logic [WORD_W-1:0] w_draw;

    assign w_ones   = '1;
    assign w_mask_w = ~(w_ones << i_req.width);
    assign w_r      = i_req.width - i_req.held;
    assign w_mask_r = ~(w_ones << w_r);

    always_comb begin
        o_res.store = i_req.store;
        o_res.held  = i_req.held;
        if (i_req.merge) begin
            if (i_req.width == WIDTH_FULL) begin
                w_draw = i_req.word;
            end else begin
                w_draw      = (i_req.store << w_r) | (i_req.word & w_mask_r);
                o_res.store = i_req.word >> w_r;
                o_res.held  = WIDTH_FULL - w_r;
            end
        end else begin
            w_draw      = i_req.store & w_mask_w;
            o_res.store = i_req.store >> i_req.width;
            o_res.held  = i_req.held - i_req.width;
        end
        o_res.draw   = w_draw;
        o_res.accept = (w_draw < i_req.modulus);
    end

endmodule

/* rtl/uniform_mod_q_rejection_sampler_core.sv */
// ----------------------------------------------------------------------------
// uniform_mod_q_rejection_sampler_core
// Turns 64-bit random words into coefficients uniform below a modulus.
// ----------------------------------------------------------------------------
// Per word: accept in S_IDLE, the draws in S_MERGE and S_DRAIN (merge plus buffered
// draws, 1 to 32), then S_FLUSH, which sends the word's last result out marked last.
// Output backpressure can stall S_MERGE, S_DRAIN and S_FLUSH; the shared draw unit
// does one draw per cycle unless so stalled.
// A modulus write keeps the block busy in S_WIDTH until the bit-width scan ends.
// Synchronous active-low reset: modulus 2, empty buffer, index 0, no output.
module uniform_mod_q_rejection_sampler_core
    import ruqs_pkg::*;
#(
    parameter int POLY_DEGREE = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [WORD_W-1:0]   i_cfg_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [WORD_W-1:0]   s_axis_tdata,   // [63:0] random_word
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OUT_TD_W-1:0] m_axis_tdata,   // [63:0] sample, [75:64] coeff_index
    output logic                m_axis_tlast    // last_of_run
);

    localparam logic [16:0] DegreeLim = 17'(POLY_DEGREE);

    t_state r_state, n_state;

    logic [WORD_W-1:0] r_modulus, n_modulus;
    logic [WORD_W-1:0] r_store, n_store;
    logic [HELD_W-1:0] r_held, n_held;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [WORD_W-1:0] r_word, n_word;

    logic              r_pend_valid, n_pend_valid;
    logic [WORD_W-1:0] r_pend_sample, n_pend_sample;
    logic [IDX_W-1:0]  r_pend_idx, n_pend_idx;

    logic              r_out_valid, n_out_valid;
    logic [WORD_W-1:0] r_out_sample, n_out_sample;
    logic [IDX_W-1:0]  r_out_idx, n_out_idx;
    logic              r_out_last, n_out_last;

    logic              w_cfg_acc;
    logic              w_in_acc;
    logic              w_slot;
    logic              w_go;
    logic              w_stall;
    logic              w_stall_f;
    logic              w_scan_busy;
    logic [HELD_W-1:0] w_width;
    logic [WORD_W-1:0] w_cfg_eff;
    logic [16:0]       w_idx_inc;
    t_draw_req         w_req;
    t_draw_res         w_res;

    ruqs_width_scan u_width_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cfg_acc),
        .i_value (w_cfg_eff),
        .o_busy  (w_scan_busy),
        .o_width (w_width)
    );

    assign w_req.merge   = (r_state == S_MERGE);
    assign w_req.store   = r_store;
    assign w_req.held    = r_held;
    assign w_req.word    = r_word;
    assign w_req.width   = w_width;
    assign w_req.modulus = r_modulus;

    ruqs_draw_unit u_draw_unit (
        .i_req (w_req),
        .o_res (w_res)
    );

    assign o_cfg_ready   = (r_state == S_IDLE);
    assign s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid;
    assign w_cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_cfg_eff     = (i_cfg_data < MODULUS_RST) ? MODULUS_RST : i_cfg_data;

    assign w_slot    = !r_out_valid || m_axis_tready;
    assign w_go      = (r_state == S_MERGE) ||
                       ((r_state == S_DRAIN) && (r_held >= w_width));
    assign w_stall   = w_go && w_res.accept && r_pend_valid && !w_slot;
    assign w_stall_f = r_pend_valid && !w_slot;
    assign w_idx_inc = {5'd0, r_idx} + 17'd1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_cfg_acc) begin
                    n_state = S_WIDTH;
                end else if (w_in_acc) begin
                    n_state = S_MERGE;
                end
            end
            S_WIDTH: begin
                if (!w_scan_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_MERGE: begin
                if (!w_stall) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!w_go) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!w_stall_f) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_modulus     = r_modulus;
        n_store       = r_store;
        n_held        = r_held;
        n_idx         = r_idx;
        n_word        = r_word;
        n_pend_valid  = r_pend_valid;
        n_pend_sample = r_pend_sample;
        n_pend_idx    = r_pend_idx;
        n_out_valid   = r_out_valid;
        n_out_sample  = r_out_sample;
        n_out_idx     = r_out_idx;
        n_out_last    = r_out_last;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_cfg_acc) begin
                    n_modulus = w_cfg_eff;
                    n_store   = '0;
                    n_held    = '0;
                end else if (w_in_acc) begin
                    n_word = s_axis_tdata;
                end
            end
            S_MERGE, S_DRAIN: begin
                if (w_go && !w_stall) begin
                    n_store = w_res.store;
                    n_held  = w_res.held;
                    if (w_res.accept) begin
                        if (r_pend_valid) begin
                            n_out_valid  = 1'b1;
                            n_out_sample = r_pend_sample;
                            n_out_idx    = r_pend_idx;
                            n_out_last   = 1'b0;
                        end
                        n_pend_valid  = 1'b1;
                        n_pend_sample = w_res.draw;
                        n_pend_idx    = r_idx;
                        n_idx         = (w_idx_inc >= DegreeLim) ? '0 : w_idx_inc[IDX_W-1:0];
                    end
                end
            end
            S_FLUSH: begin
                if (r_pend_valid && !w_stall_f) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = r_pend_sample;
                    n_out_idx    = r_pend_idx;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                end
            end
            default: begin
                n_pend_valid = r_pend_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_modulus    <= MODULUS_RST;
            r_store      <= '0;
            r_held       <= '0;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_modulus    <= n_modulus;
            r_store      <= n_store;
            r_held       <= n_held;
            r_idx        <= n_idx;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
        r_word        <= n_word;
        r_pend_sample <= n_pend_sample;
        r_pend_idx    <= n_pend_idx;
        r_out_sample  <= n_out_sample;
        r_out_idx     <= n_out_idx;
        r_out_last    <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_idx, r_out_sample};
    assign m_axis_tlast  = r_out_last;

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the uniform mod-q rejection sampler core.
// Drives random words over the input stream and modulus writes over the
// config channel. An in-bench model tracks the bit buffer and the
// coefficient index, and every output transaction is compared with it.
// ----------------------------------------------------------------------------
module tb_top;
    import ruqs_pkg::*;

    localparam int POLY_DEGREE  = 4096;
    localparam int MAX_PER_WORD = 32;
    localparam int SETTLE       = 80;
    localparam int LONG_HOLD    = 400;
    localparam int LIMIT        = 800000;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [WORD_W-1:0] sample;
        logic [IDX_W-1:0]  index;
        logic              is_last;
    } t_coeff;

    class coeff_scoreboard;
        logic [WORD_W-1:0] modulus;
        logic [WORD_W-1:0] bit_store;
        int unsigned       bits_held;
        logic [IDX_W-1:0]  next_index;
        t_coeff            word_coeffs[$];
        t_coeff            due_coeffs[$];
        int unsigned       mismatches;
        int unsigned       checked;
        int unsigned       words;
        int unsigned       index_wraps;

        function new();
            modulus     = MODULUS_RST;
            bit_store   = '0;
            bits_held   = 0;
            next_index  = '0;
            mismatches  = 0;
            checked     = 0;
            words       = 0;
            index_wraps = 0;
        endfunction

        function void load_modulus(logic [WORD_W-1:0] q);
            modulus   = q;
            bit_store = '0;
            bits_held = 0;
        endfunction

        function int unsigned bit_width(logic [WORD_W-1:0] v);
            int unsigned n;
            n = 0;
            while (v != '0) begin
                n++;
                v = v >> 1;
            end
            return n;
        endfunction

        function void accept_draw(logic [WORD_W-1:0] draw, logic [WORD_W-1:0] q);
            t_coeff c;
            int     nxt;
            if (draw >= q || word_coeffs.size() >= MAX_PER_WORD) return;
            c.sample  = draw;
            c.index   = next_index;
            c.is_last = 1'b0;
            word_coeffs.push_back(c);
            nxt = int'(next_index) + 1;
            if (nxt >= POLY_DEGREE) begin
                nxt = 0;
                index_wraps++;
            end
            next_index = IDX_W'(nxt);
        endfunction

        function void drain_held(int unsigned w, logic [WORD_W-1:0] q);
            logic [WORD_W-1:0] mask;
            logic [WORD_W-1:0] draw;
            mask = (64'd1 << w) - 64'd1;
            while (bits_held >= w) begin
                draw      = bit_store & mask;
                bit_store = bit_store >> w;
                bits_held = bits_held - w;
                accept_draw(draw, q);
            end
        endfunction

        function void note_word(logic [WORD_W-1:0] word);
            logic [WORD_W-1:0] q;
            logic [WORD_W-1:0] held_mask;
            logic [WORD_W-1:0] draw;
            int unsigned       w;
            int unsigned       r;
            q = (modulus < 64'd2) ? 64'd2 : modulus;
            w = bit_width(q);
            words++;
            word_coeffs.delete();
            if (w == WORD_W) begin
                accept_draw(word, q);
            end else begin
                drain_held(w, q);
                r         = w - bits_held;
                held_mask = (bits_held == 0) ? '0 : ((64'd1 << bits_held) - 64'd1);
                draw      = ((bit_store & held_mask) << r) | (word & ((64'd1 << r) - 64'd1));
                bit_store = word >> r;
                bits_held = WORD_W - r;
                accept_draw(draw, q);
                drain_held(w, q);
            end
            if (word_coeffs.size() > 0) word_coeffs[word_coeffs.size()-1].is_last = 1'b1;
            foreach (word_coeffs[i]) due_coeffs.push_back(word_coeffs[i]);
        endfunction

        function void check_coeff(logic [WORD_W-1:0] sample, logic [IDX_W-1:0] index,
                                  logic is_last);
            t_coeff exp_c;
            checked++;
            if (due_coeffs.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: unexpected sample %h index %0d last %0b",
                             sample, index, is_last);
                return;
            end
            exp_c = due_coeffs.pop_front();
            if (sample !== exp_c.sample || index !== exp_c.index ||
                is_last !== exp_c.is_last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: sample %h/%h index %0d/%0d last %0b/%0b (exp/act)",
                             exp_c.sample, sample, exp_c.index, index,
                             exp_c.is_last, is_last);
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [WORD_W-1:0]   i_cfg_data;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [WORD_W-1:0]   s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_TD_W-1:0] m_axis_tdata;
    logic                m_axis_tlast;

    coeff_scoreboard sb;
    int unsigned     cycles;
    int unsigned     words_sent;
    int unsigned     cfg_writes;
    int unsigned     recv_stall_pct;
    bit              hold_req;
    bit              hold_done;

    uniform_mod_q_rejection_sampler_core #(
        .POLY_DEGREE(POLY_DEGREE)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // transaction monitor and run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[uniform_mod_q_rejection_sampler_core] ERROR");
            $finish;
        end else if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.load_modulus(i_cfg_data);
            if (s_axis_tvalid && s_axis_tready) sb.note_word(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_coeff(m_axis_tdata[63:0], m_axis_tdata[75:64], m_axis_tlast);
        end
    end

    // output backpressure, with one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                m_axis_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_done = 1'b1;
            end
            m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] rand_modulus();
        int unsigned       w;
        logic [WORD_W-1:0] v;
        case ($urandom_range(0, 3))
            0:       w = $urandom_range(2, 12);
            1, 2:    w = $urandom_range(50, 60);
            default: w = $urandom_range(13, 64);
        endcase
        v = {$urandom, $urandom};
        if (w < WORD_W) v = v & ((64'd1 << w) - 64'd1);
        v[w-1] = 1'b1;
        return v;
    endfunction

    task automatic send_word(input logic [WORD_W-1:0] word);
        int unsigned gap_pct;
        gap_pct        = (words_sent < 133) ? 24 : (words_sent < 266) ? 45 : 0;
        recv_stall_pct = (words_sent < 133) ? 45 : (words_sent < 266) ? 24 : 0;
        while ($urandom_range(0, 99) < gap_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = word;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic wait_drained();
        while (sb.due_coeffs.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_modulus(input logic [WORD_W-1:0] q);
        s_axis_tvalid = 1'b0;
        wait_drained();
        i_cfg_valid = 1'b1;
        i_cfg_data  = q;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        cfg_writes++;
    endtask

    initial begin
        sb             = new();
        cycles         = 0;
        words_sent     = 0;
        cfg_writes     = 0;
        recv_stall_pct = 45;
        hold_req       = 1'b0;
        hold_done      = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset modulus: zeros give a full run, ones give no result
        send_word('0);
        send_word('1);
        // moduli below two behave as two
        write_modulus('0);
        send_word(64'h5555_5555_5555_5555);
        write_modulus(64'd1);
        send_word(rand_word());
        // full-width moduli: one draw per word; then moduli of other widths
        write_modulus('1);
        send_word('0);
        send_word('1);
        send_word(64'hFFFF_FFFF_FFFF_FFFE);
        write_modulus(64'h8000_0000_0000_0000);
        send_word(64'h7FFF_FFFF_FFFF_FFFF);
        send_word(64'h8000_0000_0000_0000);
        write_modulus(64'h7FFF_FFFF_FFFF_FFFF);
        send_word('1);
        send_word('0);
        send_word(rand_word());
        send_word(rand_word());
        write_modulus(64'd5);
        send_word(rand_word());
        send_word(rand_word());
        write_modulus(64'h7FF);
        send_word(rand_word());
        send_word(rand_word());
        write_modulus(64'h1FFF_FFFF_FFFF_FFFF);
        repeat (3) send_word(rand_word());

        // narrow modulus: many coefficients per word, carries the index past wrap
        write_modulus(64'd3);
        for (int i = 0; i < 175; i++) begin
            if (i == 20) hold_req = 1'b1;
            send_word(rand_word());
        end

        for (int p = 0; p < 8; p++) begin
            write_modulus(rand_modulus());
            repeat (26) send_word(rand_word());
        end
        s_axis_tvalid = 1'b0;

        wait_drained();
        $display("%0d words over %0d modulus writes, %0d coefficients checked",
                 sb.words, cfg_writes, sb.checked);
        $display("index wrapped %0d times, long output hold-off exercised", sb.index_wraps);
        if (sb.mismatches == 0) begin
            $display("[uniform_mod_q_rejection_sampler_core] OK");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("[uniform_mod_q_rejection_sampler_core] ERROR");
        end
        $finish;
    end

endmodule
